FILE: rtl/core/rbd_pkg.sv
package rbd_pkg;

    // deque geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // beat field widths
    localparam int WORD_W = 32;
    localparam int FILL_W = 5;

    // word reported when nothing was popped
    localparam logic [WORD_W-1:0] NONE_WORD = {WORD_W{1'b1}};

    // operation codes
    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_POP_FRONT  = 2'd1,
        MODE_PUSH_BACK  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_POP_READ
    } t_state;

    // one result beat
    typedef struct packed {
        logic signed [WORD_W-1:0] popped_word;
        logic                     was_empty;
        logic                     push_rejected;
        logic                     matches_expected;
        logic [FILL_W-1:0]        fill_count;
        logic                     now_empty;
    } t_result;

    // word store access
    typedef struct packed {
        logic              we;
        logic              re;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] wdata;
    } t_mem_req;

endpackage

FILE: rtl/core/rbd_ram.sv
module rbd_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/rbd_ctrl.sv
module rbd_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_mode,
    input  logic [rbd_pkg::WORD_W-1:0] i_value,
    input  logic                       i_outq_full,
    output rbd_pkg::t_mem_req          o_mem_req,
    input  logic [rbd_pkg::WORD_W-1:0] i_mem_rdata,
    output logic                       o_res_valid,
    output rbd_pkg::t_result           o_res
);

    localparam int IDX_W  = rbd_pkg::IDX_W;
    localparam int CNT_W  = rbd_pkg::CNT_W;
    localparam int FILL_W = rbd_pkg::FILL_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(rbd_pkg::CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rbd_pkg::CAPACITY);

    rbd_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_back, n_back;
    logic [CNT_W-1:0] r_count, n_count;
    logic [rbd_pkg::WORD_W-1:0] r_expect, n_expect;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic [IDX_W-1:0]   w_front_next;
    logic [IDX_W-1:0]   w_front_prev;
    logic [IDX_W-1:0]   w_back_next;
    logic [IDX_W-1:0]   w_back_prev;
    logic [CNT_W+FILL_W-1:0] w_fill_ext;

    assign w_full  = (r_count == CNT_FULL);
    assign w_empty = (r_count == '0);

    // wrapping index neighbors
    assign w_front_next = (r_front == IDX_LAST) ? '0 : r_front + 1'b1;
    assign w_front_prev = (r_front == '0) ? IDX_LAST : r_front - 1'b1;
    assign w_back_next  = (r_back == IDX_LAST) ? '0 : r_back + 1'b1;
    assign w_back_prev  = (r_back == '0) ? IDX_LAST : r_back - 1'b1;

    // input stalls while a pop waits for the store read or the output skid stage is full
    assign o_in_stall = (r_state == rbd_pkg::ST_POP_READ) || i_outq_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    // fill count masked to the beat width
    assign w_fill_ext = {{FILL_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbd_pkg::ST_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_expect <= n_expect;
    end

    // operation decode, index update and result build
    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        n_expect = r_expect;

        o_mem_req.we    = 1'b0;
        o_mem_req.re    = 1'b0;
        o_mem_req.addr  = r_front;
        o_mem_req.wdata = i_value;

        o_res_valid            = 1'b0;
        o_res.popped_word      = rbd_pkg::NONE_WORD;
        o_res.was_empty        = 1'b0;
        o_res.push_rejected    = 1'b0;
        o_res.matches_expected = 1'b1;

        unique case (r_state)
            rbd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_expect = i_value;
                    unique case (rbd_pkg::t_mode'(i_mode))
                        rbd_pkg::MODE_PUSH_FRONT: begin
                            o_res_valid         = 1'b1;
                            o_res.push_rejected = w_full;
                            if (!w_full) begin
                                n_front        = w_front_prev;
                                n_count        = r_count + 1'b1;
                                o_mem_req.we   = 1'b1;
                                o_mem_req.addr = w_front_prev;
                            end
                        end
                        rbd_pkg::MODE_PUSH_BACK: begin
                            o_res_valid         = 1'b1;
                            o_res.push_rejected = w_full;
                            if (!w_full) begin
                                n_back         = w_back_next;
                                n_count        = r_count + 1'b1;
                                o_mem_req.we   = 1'b1;
                                o_mem_req.addr = r_back;
                            end
                        end
                        rbd_pkg::MODE_POP_FRONT: begin
                            if (w_empty) begin
                                o_res_valid            = 1'b1;
                                o_res.was_empty        = 1'b1;
                                o_res.matches_expected = (i_value == rbd_pkg::NONE_WORD);
                            end else begin
                                n_front        = w_front_next;
                                n_count        = r_count - 1'b1;
                                o_mem_req.re   = 1'b1;
                                o_mem_req.addr = r_front;
                                n_state        = rbd_pkg::ST_POP_READ;
                            end
                        end
                        rbd_pkg::MODE_POP_BACK: begin
                            if (w_empty) begin
                                o_res_valid            = 1'b1;
                                o_res.was_empty        = 1'b1;
                                o_res.matches_expected = (i_value == rbd_pkg::NONE_WORD);
                            end else begin
                                n_back         = w_back_prev;
                                n_count        = r_count - 1'b1;
                                o_mem_req.re   = 1'b1;
                                o_mem_req.addr = w_back_prev;
                                n_state        = rbd_pkg::ST_POP_READ;
                            end
                        end
                        default: begin
                            o_res_valid = 1'b0;
                        end
                    endcase
                end
            end
            rbd_pkg::ST_POP_READ: begin
                // store word has arrived, count already updated
                o_res_valid            = 1'b1;
                o_res.popped_word      = i_mem_rdata;
                o_res.matches_expected = (i_mem_rdata == r_expect);
                n_state                = rbd_pkg::ST_IDLE;
            end
            default: begin
                n_state = rbd_pkg::ST_IDLE;
            end
        endcase

        o_res.fill_count = w_fill_ext[FILL_W-1:0];
        o_res.now_empty  = (n_count == '0);
    end

    // count stays within the store
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("deque count exceeds capacity");

    // empty or full deque has coinciding indices
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_FULL) |-> (r_front == r_back))
        else $error("indices disagree with count");

    // a pop on a non-empty deque yields its result from the store next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_req.re) |=> (r_state == rbd_pkg::ST_POP_READ && o_res_valid))
        else $error("pop read did not complete");

    // store is never written and read in the same cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.we && o_mem_req.re))
        else $error("store write and read collide");

endmodule

FILE: rtl/core/rbd_outq.sv
module rbd_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  rbd_pkg::t_result i_res,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output rbd_pkg::t_result o_res,
    output logic             o_full
);

    logic             r_out_valid;
    logic             r_skid_valid;
    rbd_pkg::t_result r_out;
    rbd_pkg::t_result r_skid;
    logic             w_load;

    // output register free or being taken this cycle
    assign w_load = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_res_valid;
            end
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload moves without reset
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_res_valid) begin
                r_out <= i_res;
            end
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_full      = r_skid_valid;

    // a new result never meets an occupied skid stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_skid_valid && i_res_valid))
        else $error("skid stage overrun");

    // skid stage only holds a beat behind the output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat without output beat");

    // a result arriving at a stalled output parks in the skid stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && i_res_valid) |=> r_skid_valid)
        else $error("result lost at stalled output");

endmodule

FILE: rtl/core/ring_buffer_deque.sv
// result path: push, rejected push and pop on empty give their result through the output register;
//   a pop that reads the store gives it through the registered store read and then the output register
// throughput: one push per cycle while the output skid stage is not full; a pop that reads the store
//   stalls the input until its word returns from the registered read of the single-port word store
// reset: synchronous active-low clears indices, count and handshake state; the store is not cleared
module ring_buffer_deque (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_mode,
    input  logic signed [rbd_pkg::WORD_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [rbd_pkg::WORD_W-1:0] o_popped_word,
    output logic                              o_was_empty,
    output logic                              o_push_rejected,
    output logic                              o_matches_expected,
    output logic [rbd_pkg::FILL_W-1:0]        o_fill_count,
    output logic                              o_now_empty
);

    rbd_pkg::t_mem_req          w_mem_req;
    logic [rbd_pkg::WORD_W-1:0] w_mem_rdata;
    logic                       w_res_valid;
    rbd_pkg::t_result           w_res;
    rbd_pkg::t_result           w_out;
    logic                       w_outq_full;

    // index, count and operation control
    rbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .i_outq_full (w_outq_full),
        .o_mem_req   (w_mem_req),
        .i_mem_rdata (w_mem_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // word store
    rbd_ram #(
        .DEPTH (rbd_pkg::CAPACITY),
        .WIDTH (rbd_pkg::WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_req.we),
        .i_re    (w_mem_req.re),
        .i_addr  (w_mem_req.addr),
        .i_wdata (w_mem_req.wdata),
        .o_rdata (w_mem_rdata)
    );

    // output register with skid stage
    rbd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (w_out),
        .o_full      (w_outq_full)
    );

    // result beat fields
    assign o_popped_word      = w_out.popped_word;
    assign o_was_empty        = w_out.was_empty;
    assign o_push_rejected    = w_out.push_rejected;
    assign o_matches_expected = w_out.matches_expected;
    assign o_fill_count       = w_out.fill_count;
    assign o_now_empty        = w_out.now_empty;

endmodule

FILE: tb/sv/ring_buffer_deque_tb.sv
module ring_buffer_deque_tb;

    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_PCT     = 33;
    localparam int RANDOM_ITEMS = 330;
    localparam int PHASE_ITEMS  = 50;
    localparam int MAX_REPORTS  = 10;

    localparam int WORD_W   = rbd_pkg::WORD_W;
    localparam int FILL_W   = rbd_pkg::FILL_W;
    localparam int CAPACITY = rbd_pkg::CAPACITY;
    localparam logic [WORD_W-1:0] NONE_WORD = rbd_pkg::NONE_WORD;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               in_mode = rbd_pkg::MODE_PUSH_FRONT;
    logic signed [WORD_W-1:0] in_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [WORD_W-1:0] popped_word;
    logic                     was_empty;
    logic                     push_rejected;
    logic                     matches_expected;
    logic [FILL_W-1:0]        fill_count;
    logic                     now_empty;

    // deque mirror
    logic [WORD_W-1:0] deque_store [CAPACITY];
    int                deque_front = 0;
    int                deque_back  = 0;
    int                deque_count = 0;

    rbd_pkg::t_result expected_results [$];
    int               error_count = 0;

    // idling controls
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int hold_req_id  = 0;
    int hold_done_id = 0;
    int hold_left    = 0;

    ring_buffer_deque dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_mode             (in_mode),
        .i_value            (in_value),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_popped_word      (popped_word),
        .o_was_empty        (was_empty),
        .o_push_rejected    (push_rejected),
        .o_matches_expected (matches_expected),
        .o_fill_count       (fill_count),
        .o_now_empty        (now_empty)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // deque behavior for one accepted beat
    function automatic rbd_pkg::t_result apply_op(input rbd_pkg::t_mode m,
                                                  input logic [WORD_W-1:0] v);
        rbd_pkg::t_result r;
        r.popped_word      = NONE_WORD;
        r.was_empty        = 1'b0;
        r.push_rejected    = 1'b0;
        r.matches_expected = 1'b1;
        if (m == rbd_pkg::MODE_PUSH_FRONT || m == rbd_pkg::MODE_PUSH_BACK) begin
            if (deque_count >= CAPACITY) begin
                r.push_rejected = 1'b1;
            end else if (m == rbd_pkg::MODE_PUSH_FRONT) begin
                deque_front = (deque_front == 0) ? CAPACITY - 1 : deque_front - 1;
                deque_store[deque_front] = v;
                deque_count++;
            end else begin
                deque_store[deque_back] = v;
                deque_back = (deque_back == CAPACITY - 1) ? 0 : deque_back + 1;
                deque_count++;
            end
        end else begin
            if (deque_count == 0) begin
                r.was_empty = 1'b1;
            end else if (m == rbd_pkg::MODE_POP_FRONT) begin
                r.popped_word = deque_store[deque_front];
                deque_front = (deque_front == CAPACITY - 1) ? 0 : deque_front + 1;
                deque_count--;
            end else begin
                deque_back = (deque_back == 0) ? CAPACITY - 1 : deque_back - 1;
                r.popped_word = deque_store[deque_back];
                deque_count--;
            end
            r.matches_expected = (r.popped_word == v);
        end
        r.fill_count = FILL_W'(deque_count);
        r.now_empty  = (deque_count == 0);
        return r;
    endfunction

    // word the next pop at that end would remove
    function automatic logic [WORD_W-1:0] next_pop_word(input rbd_pkg::t_mode m);
        if (deque_count == 0)
            return NONE_WORD;
        if (m == rbd_pkg::MODE_POP_FRONT)
            return deque_store[deque_front];
        return deque_store[(deque_back == 0) ? CAPACITY - 1 : deque_back - 1];
    endfunction

    // random word with extremes mixed in
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // send one input beat, optional random idle before it
    task automatic send_op(input rbd_pkg::t_mode m, input logic [WORD_W-1:0] v);
        @(negedge clk);
        while (send_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid = 1'b0;
            in_mode  = 2'($urandom_range(0, 3));
            in_value = $urandom;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_mode  = m;
        in_value = v;
        do @(posedge clk); while (in_stall);
        expected_results = {expected_results, apply_op(m, v)};
    endtask

    // random op, pushes with probability push_pct
    task automatic send_random(input int push_pct);
        rbd_pkg::t_mode m;
        logic [WORD_W-1:0] v;
        if ($urandom_range(0, 99) < push_pct) begin
            m = $urandom_range(0, 1) ? rbd_pkg::MODE_PUSH_BACK : rbd_pkg::MODE_PUSH_FRONT;
            v = rand_word();
        end else begin
            m = $urandom_range(0, 1) ? rbd_pkg::MODE_POP_BACK : rbd_pkg::MODE_POP_FRONT;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: v = next_pop_word(m);
                5:             v = NONE_WORD;
                default:       v = rand_word();
            endcase
        end
        send_op(m, v);
    endtask

    // drop valid and wait for every outstanding result
    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver stall: long hold on request, otherwise random while recv_idle is set
    always @(negedge clk) begin
        if (hold_req_id != hold_done_id) begin
            hold_done_id = hold_req_id;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else if (recv_idle) begin
            out_stall = ($urandom_range(0, 99) < IDLE_PCT);
        end else begin
            out_stall = 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("mismatch %s: expected %h, got %h at %0t", name, want, got, $realtime);
        end
    endtask

    // result beat checker
    always @(posedge clk) begin
        rbd_pkg::t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result beat: word %h fill %0d at %0t",
                             popped_word, fill_count, $realtime);
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                check_field("popped_word", want.popped_word, popped_word);
                check_field("was_empty", WORD_W'(want.was_empty), WORD_W'(was_empty));
                check_field("push_rejected", WORD_W'(want.push_rejected),
                            WORD_W'(push_rejected));
                check_field("matches_expected", WORD_W'(want.matches_expected),
                            WORD_W'(matches_expected));
                check_field("fill_count", WORD_W'(want.fill_count), WORD_W'(fill_count));
                check_field("now_empty", WORD_W'(want.now_empty), WORD_W'(now_empty));
            end
        end
    end

    // empty pops, field extremes, front index wrap in both directions
    task automatic test_directed();
        send_op(rbd_pkg::MODE_POP_FRONT, 32'hffff_ffff);
        send_op(rbd_pkg::MODE_POP_BACK, 32'h0000_0000);
        send_op(rbd_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
        send_op(rbd_pkg::MODE_PUSH_BACK, 32'h7fff_ffff);
        send_op(rbd_pkg::MODE_PUSH_FRONT, 32'h0000_0000);
        send_op(rbd_pkg::MODE_PUSH_BACK, 32'hffff_ffff);
        send_op(rbd_pkg::MODE_POP_FRONT, 32'h0000_0000);
        send_op(rbd_pkg::MODE_POP_BACK, 32'h0000_0000);
        send_op(rbd_pkg::MODE_POP_FRONT, 32'h8000_0000);
        send_op(rbd_pkg::MODE_POP_BACK, 32'h7fff_ffff);
        send_op(rbd_pkg::MODE_POP_BACK, 32'hffff_ffff);
        send_op(rbd_pkg::MODE_PUSH_BACK, 32'h5555_5555);
        send_op(rbd_pkg::MODE_POP_FRONT, 32'haaaa_aaaa);
        send_op(rbd_pkg::MODE_POP_FRONT, 32'h1234_5678);
    endtask

    // receiver holds off while pushes keep coming: deque fills, pushes get rejected
    task automatic test_backpressure();
        wait_drain();
        send_idle = 1'b0;
        hold_req_id++;
        for (int i = 0; i < 20; i++)
            send_op((i % 2) ? rbd_pkg::MODE_PUSH_BACK : rbd_pkg::MODE_PUSH_FRONT, rand_word());
        send_idle = 1'b1;
        for (int i = 0; i < 18; i++)
            send_random(0);
    endtask

    // sender pauses until every result is back
    task automatic test_pause();
        for (int i = 0; i < 10; i++)
            send_random(60);
        wait_drain();
        for (int i = 0; i < 10; i++)
            send_random(40);
    endtask

    // random ops in phases that drive the deque to full and to empty
    task automatic test_random();
        int push_pct;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % PHASE_ITEMS == 0) begin
                case ((i / PHASE_ITEMS) % 5)
                    0: push_pct = 90;
                    1: push_pct = 15;
                    2: push_pct = 50;
                    3: push_pct = 97;
                    default: push_pct = 5;
                endcase
                // first phases run with no idling on either side
                send_idle = (i >= 2 * PHASE_ITEMS) ? ($urandom_range(0, 3) != 0) : 1'b0;
                recv_idle = (i >= 2 * PHASE_ITEMS) ? ($urandom_range(0, 3) != 0) : 1'b0;
            end
            send_random(push_pct);
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_pause();
        test_random();
        wait_drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
